@@ rtl/core/sm4_block_cipher_defines.svh @@
// Assertion helpers for the SM4 checker.
`ifndef SM4_BLOCK_CIPHER_DEFINES_SVH
`define SM4_BLOCK_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SM4_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sm4 check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SM4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sm4 check failed");

`endif

@@ rtl/core/sm4_pkg.sv @@
package sm4_pkg;

  localparam int ROUNDS = 32;
  localparam int RK_AW  = $clog2(ROUNDS);
  localparam int WORD_W = 32;
  localparam int HALF_W = 64;
  localparam int CFG_W  = 64;
  localparam int CFG_IW = 2;

  typedef logic [WORD_W-1:0] word_t;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_KEY_HIGH,
    REG_KEY_LOW,
    REG_DECRYPT_MODE
  } cfg_reg_t;

  // Linear layer select for the shared round unit
  typedef enum logic {
    LIN_DATA,
    LIN_KEY
  } lin_sel_t;

  localparam word_t FK0 = 32'ha3b1bac6;
  localparam word_t FK1 = 32'h56aa3350;
  localparam word_t FK2 = 32'h677d9197;
  localparam word_t FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // CK constant for key round i: byte j (msb first) is (4*i + j) * 7 mod 256
  function automatic word_t ck_word(input logic [RK_AW-1:0] i);
    logic [7:0] b;
    word_t      w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'({i, 2'(j)});
      w[WORD_W-1-8*j -: 8] = 8'((b << 3) - b);
    end
    return w;
  endfunction

endpackage

@@ rtl/core/sm4_block_cipher.sv @@
// SM4 block cipher, 128-bit block and key, one round per clock through a
// single shared round unit (S-box plus linear layer) and a 32-word round key
// RAM with one read port. A block is taken when in_valid is high and
// in_stall low; in_stall is high while a block is in work. An accepted block
// passes through PREP (fetch of the first round key), ROUND (the cipher rounds,
// one per clock) and FLUSH (load of the output register, which waits while a
// held result is still stalled), and the next block can be taken only once the
// engine is back in IDLE. After reset or a write to key_high or key_low, the
// next block first runs the key schedule through the same round unit.
// The output register holds a finished result while out_stall is high, and
// the next block may be taken meanwhile. decrypt_mode selects decryption
// (round keys read in reverse) starting at the next block. Write
// configuration only while no block is in flight.
module sm4_block_cipher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [sm4_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sm4_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sm4_pkg::HALF_W-1:0]  block_high,
  input  logic [sm4_pkg::HALF_W-1:0]  block_low,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sm4_pkg::HALF_W-1:0]  result_high,
  output logic [sm4_pkg::HALF_W-1:0]  result_low
);
  import sm4_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYGEN,
    ST_PREP,
    ST_ROUND,
    ST_FLUSH
  } state_t;

  state_t             state;
  logic [HALF_W-1:0]  key_high;
  logic [HALF_W-1:0]  key_low;
  logic               decrypt_mode;
  logic               keys_stale;
  logic [RK_AW-1:0]   cnt;
  word_t              w [4];
  logic [HALF_W-1:0]  blk_high;
  logic [HALF_W-1:0]  blk_low;

  logic               in_beat;
  logic               out_free;
  logic [RK_AW-1:0]   rd_round;
  logic [RK_AW-1:0]   rk_rd_addr;
  word_t              rk_rd_data;
  word_t              rnd_in;
  word_t              rnd_out;
  word_t              new_word;
  lin_sel_t           lin_sel;

  assign in_stall = (state != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // round key fetch: one round ahead, reversed for decryption
  always_comb begin
    rd_round   = (state == ST_PREP) ? cnt : cnt + 1'b1;
    rk_rd_addr = decrypt_mode ? RK_AW'(ROUNDS - 1) - rd_round : rd_round;
  end

  // shared round unit operand and result
  always_comb begin
    lin_sel  = (state == ST_KEYGEN) ? LIN_KEY : LIN_DATA;
    rnd_in   = w[1] ^ w[2] ^ w[3] ^ ((state == ST_KEYGEN) ? ck_word(cnt) : rk_rd_data);
    new_word = w[0] ^ rnd_out;
  end

  sm4_round u_round (
    .x   (rnd_in),
    .sel (lin_sel),
    .y   (rnd_out)
  );

  sm4_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROUNDS)
  ) u_rk_ram (
    .clk     (clk),
    .wr_en   (state == ST_KEYGEN),
    .wr_addr (cnt),
    .wr_data (new_word),
    .rd_addr (rk_rd_addr),
    .rd_data (rk_rd_data)
  );

  // sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      key_high     <= '0;
      key_low      <= '0;
      decrypt_mode <= 1'b0;
      keys_stale   <= 1'b1;
      cnt          <= '0;
      out_valid    <= 1'b0;
    end else begin
      // FLUSH reloads the output register itself
      if (out_valid && !out_stall && state != ST_FLUSH) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_KEY_HIGH: begin
            key_high   <= cfg_wdata;
            keys_stale <= 1'b1;
          end
          REG_KEY_LOW: begin
            key_low    <= cfg_wdata;
            keys_stale <= 1'b1;
          end
          REG_DECRYPT_MODE: decrypt_mode <= cfg_wdata[0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            blk_high <= block_high;
            blk_low  <= block_low;
            cnt      <= '0;
            if (keys_stale) begin
              w[0]  <= key_high[HALF_W-1 -: WORD_W] ^ FK0;
              w[1]  <= key_high[WORD_W-1:0] ^ FK1;
              w[2]  <= key_low[HALF_W-1 -: WORD_W] ^ FK2;
              w[3]  <= key_low[WORD_W-1:0] ^ FK3;
              state <= ST_KEYGEN;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_KEYGEN: begin
          w[0] <= w[1];
          w[1] <= w[2];
          w[2] <= w[3];
          w[3] <= new_word;
          cnt  <= cnt + 1'b1;
          if (cnt == RK_AW'(ROUNDS - 1)) begin
            keys_stale <= 1'b0;
            state      <= ST_PREP;
          end
        end
        ST_PREP: begin
          w[0]  <= blk_high[HALF_W-1 -: WORD_W];
          w[1]  <= blk_high[WORD_W-1:0];
          w[2]  <= blk_low[HALF_W-1 -: WORD_W];
          w[3]  <= blk_low[WORD_W-1:0];
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          w[0] <= w[1];
          w[1] <= w[2];
          w[2] <= w[3];
          w[3] <= new_word;
          cnt  <= cnt + 1'b1;
          if (cnt == RK_AW'(ROUNDS - 1)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            result_high <= {w[3], w[2]};
            result_low  <= {w[1], w[0]};
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/sm4_ram.sv @@
module sm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/sm4_round.sv @@
module sm4_round (
  input  sm4_pkg::word_t    x,
  input  sm4_pkg::lin_sel_t sel,
  output sm4_pkg::word_t    y
);
  import sm4_pkg::*;

  word_t t;

  function automatic word_t rotl(input word_t v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // byte-wise S-box
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      t[8*b +: 8] = SBOX[x[8*b +: 8]];
    end
  end

  // linear layer: key schedule or data path flavor
  always_comb begin
    case (sel)
      LIN_KEY: y = t ^ rotl(t, 13) ^ rotl(t, 23);
      default: y = t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
    endcase
  end

endmodule

@@ rtl/core/sm4_checker.sv @@
`include "sm4_block_cipher_defines.svh"

module sm4_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sm4_pkg::HALF_W-1:0] result_high,
  input logic [sm4_pkg::HALF_W-1:0] result_low
);

  // a held result beat stays up and steady
  `SM4_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `SM4_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                   $stable(result_high) && $stable(result_low))
  // an accepted block keeps the engine busy and cannot finish at once
  `SM4_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall,
                   in_stall && !$rose(out_valid))
  // a result is posted on the edge the engine goes idle
  `SM4_ASSERT_NOW(a_done_idle, $rose(out_valid), !in_stall)

endmodule

bind sm4_block_cipher sm4_checker u_sm4_checker (.*);

@@ dv/sm4_block_cipher_tb.sv @@
`timescale 1ns / 100ps

module sm4_block_cipher_tb;
  import sm4_pkg::*;

  typedef logic [31:0] word32_t;

  typedef struct packed {
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
  } cipher_block_t;

  localparam int NUM_ROUNDS = 32;

  // Index just past the last register; writes to it must be dropped
  localparam logic [CFG_IW-1:0] REG_SPARE = 2'd3;

  localparam word32_t FK_0 = 32'ha3b1bac6;
  localparam word32_t FK_1 = 32'h56aa3350;
  localparam word32_t FK_2 = 32'h677d9197;
  localparam word32_t FK_3 = 32'hb27022dc;

  // Published SM4 example: key and plaintext are the same 128-bit value
  localparam cipher_block_t KAT_PLAIN  = {64'h0123456789abcdef, 64'hfedcba9876543210};
  localparam cipher_block_t KAT_CIPHER = {64'h681edf34d206965e, 64'h86b3e94f536e4246};

  // S-box, entry 0 in the top byte
  localparam logic [2047:0] SBOX_BITS = {
    128'hd690e9fecce13db716b614c228fb2c05,
    128'h2b679a762abe04c3aa44132649860699,
    128'h9c4250f491ef987a33540b43edcfac62,
    128'he4b31ca9c908e89580df94fa758f3fa6,
    128'h4707a7fcf37317ba83593c19e6854fa8,
    128'h686b81b27164da8bf8eb0f4b70569d35,
    128'h1e240e5e6358d1a225227c3b01217887,
    128'hd40046579fd327524c3602e7a0c4c89e,
    128'heabf8ad240c738b5a3f7f2cef96115a1,
    128'he0ae5da49b341a55ad933230f58cb1e3,
    128'h1df6e22e8266ca60c02923ab0d534e6f,
    128'hd5db3745defd8e2f03ff6a726d6c5b51,
    128'h8d1baf92bbddbc7f11d95c411f105ad8,
    128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
    128'h8969974a0c96777e65b9f109c56ec684,
    128'h18f07dec3adc4d2079ee5f3ed7cb3948
  };

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic [HALF_W-1:0] block_high;
  logic [HALF_W-1:0] block_low;
  logic              out_valid;
  logic              out_stall;
  logic [HALF_W-1:0] result_high;
  logic [HALF_W-1:0] result_low;

  // Shadow of the cipher state
  logic [HALF_W-1:0] shadow_key_high;
  logic [HALF_W-1:0] shadow_key_low;
  logic              shadow_decrypt;
  word32_t           round_keys [NUM_ROUNDS];
  logic              round_keys_stale;

  cipher_block_t expected_blocks [$];

  int  error_count;
  int  blocks_sent;
  int  results_checked;
  int  key_schedules;
  int  decrypt_blocks;
  int  hold_cycles;
  logic no_idle;

  sm4_block_cipher dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .block_high (block_high),
    .block_low  (block_low),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_high(result_high),
    .result_low (result_low)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cipher predictor
  // ---------------------------------------------------------------------------

  function automatic word32_t sbox_word(input word32_t x);
    word32_t y;
    for (int b = 0; b < 4; b++)
      y[31-8*b -: 8] = SBOX_BITS[2047 - 8*int'(x[31-8*b -: 8]) -: 8];
    return y;
  endfunction

  function automatic word32_t rotl(input word32_t x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void expand_round_keys();
    word32_t k [4];
    word32_t t;
    word32_t ck;
    k[0] = shadow_key_high[63:32] ^ FK_0;
    k[1] = shadow_key_high[31:0]  ^ FK_1;
    k[2] = shadow_key_low[63:32]  ^ FK_2;
    k[3] = shadow_key_low[31:0]   ^ FK_3;
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      // CK byte j of round i is (4i + j) * 7 mod 256, msb first
      ck = '0;
      for (int j = 0; j < 4; j++)
        ck = (ck << 8) | word32_t'(((4 * i + j) * 7) % 256);
      t = sbox_word(k[1] ^ k[2] ^ k[3] ^ ck);
      t = t ^ rotl(t, 13) ^ rotl(t, 23);
      round_keys[i] = k[0] ^ t;
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = round_keys[i];
    end
    round_keys_stale = 1'b0;
    key_schedules++;
  endfunction

  function automatic cipher_block_t sm4_transform(input logic [HALF_W-1:0] hi,
                                                  input logic [HALF_W-1:0] lo);
    word32_t       x [4];
    word32_t       t;
    cipher_block_t res;
    if (round_keys_stale)
      expand_round_keys();
    x[0] = hi[63:32];
    x[1] = hi[31:0];
    x[2] = lo[63:32];
    x[3] = lo[31:0];
    for (int rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
      t = sbox_word(x[1] ^ x[2] ^ x[3] ^
                    round_keys[shadow_decrypt ? NUM_ROUNDS - 1 - rnd : rnd]);
      t = t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24) ^ x[0];
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = t;
    end
    // output words come out reversed
    res.high = {x[3], x[2]};
    res.low  = {x[1], x[0]};
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One register write; the shadow copy follows it
  task automatic write_cfg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_KEY_HIGH: begin
        shadow_key_high  = value;
        round_keys_stale = 1'b1;
      end
      REG_KEY_LOW: begin
        shadow_key_low   = value;
        round_keys_stale = 1'b1;
      end
      REG_DECRYPT_MODE: shadow_decrypt = value[0];
      default: ;
    endcase
  endtask

  // Send one block beat and queue its predicted result
  task automatic send_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
                            output cipher_block_t predicted);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    block_high <= hi;
    block_low  <= lo;
    do @(posedge clk); while (in_stall);
    predicted = sm4_transform(hi, lo);
    expected_blocks.push_back(predicted);
    blocks_sent++;
    if (shadow_decrypt)
      decrypt_blocks++;
    // beat taken: drop valid so it is not taken again
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for every outstanding result, leave the input idle
  task automatic wait_drain();
    while (expected_blocks.size() != 0)
      @(posedge clk);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [HALF_W-1:0] pick_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall while a result is showing, then check it
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      if (out_valid)
        hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cipher_block_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $display("%0t: result beat with nothing expected: %h %h",
                 $time, result_high, result_low);
        error_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (result_high !== want.high) begin
          $display("%0t: result_high expected %h actual %h", $time, want.high, result_high);
          error_count++;
        end
        if (result_low !== want.low) begin
          $display("%0t: result_low expected %h actual %h", $time, want.low, result_low);
          error_count++;
        end
      end
      results_checked++;
      hold_cycles <= no_idle ? 0 : $urandom_range(0, 14);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes, key and mode changes, register corner cases
  task automatic test_directed();
    cipher_block_t got;
    // zero key straight out of reset, schedule runs before the first block
    send_block('0, '0, got);
    send_block('1, '1, got);
    wait_drain();

    write_cfg(REG_KEY_HIGH, KAT_PLAIN.high);
    write_cfg(REG_KEY_LOW, KAT_PLAIN.low);
    send_block(KAT_PLAIN.high, KAT_PLAIN.low, got);
    if (got !== KAT_CIPHER) begin
      $display("%0t: predictor off the known vector: expected %h actual %h",
               $time, KAT_CIPHER, got);
      error_count++;
    end
    send_block(64'h8000_0000_0000_0000, 64'h1, got);
    send_block(64'h1, 64'h8000_0000_0000_0000, got);
    wait_drain();

    // mode change alone: no new schedule
    write_cfg(REG_DECRYPT_MODE, 64'h1);
    send_block(KAT_CIPHER.high, KAT_CIPHER.low, got);
    if (got !== KAT_PLAIN) begin
      $display("%0t: predictor decrypt off the known vector: expected %h actual %h",
               $time, KAT_PLAIN, got);
      error_count++;
    end
    send_block('1, '0, got);
    wait_drain();

    // only bit 0 of the mode value counts
    write_cfg(REG_DECRYPT_MODE, 64'hffff_ffff_ffff_fffe);
    send_block('0, '1, got);
    send_block(KAT_PLAIN.high, KAT_PLAIN.low, got);
    wait_drain();

    // write past the last register changes nothing
    write_cfg(REG_SPARE, '1);
    send_block(KAT_PLAIN.high, KAT_PLAIN.low, got);
    wait_drain();

    // one key half changed forces a new schedule
    write_cfg(REG_KEY_LOW, '1);
    send_block('0, '0, got);
    send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, got);
    wait_drain();

    write_cfg(REG_KEY_HIGH, '1);
    write_cfg(REG_DECRYPT_MODE, 64'h8000_0000_0000_0001);
    send_block('0, '0, got);
    send_block('1, '1, got);
    wait_drain();

    // zero key again, back-to-back beats with no idling either side
    write_cfg(REG_KEY_HIGH, '0);
    write_cfg(REG_KEY_LOW, '0);
    write_cfg(REG_DECRYPT_MODE, '0);
    no_idle = 1'b1;
    repeat (6) send_block(pick_half(), pick_half(), got);
    no_idle = 1'b0;
    wait_drain();
  endtask

  // Encrypt a batch under a fresh key, then decrypt what came out
  task automatic test_roundtrip(input int n_blocks);
    cipher_block_t plain [$];
    cipher_block_t sealed [$];
    cipher_block_t pt;
    cipher_block_t got;
    wait_drain();
    write_cfg(REG_KEY_HIGH, {$urandom, $urandom});
    write_cfg(REG_KEY_LOW, {$urandom, $urandom});
    write_cfg(REG_DECRYPT_MODE, '0);
    repeat (n_blocks) begin
      pt.high = pick_half();
      pt.low  = pick_half();
      send_block(pt.high, pt.low, got);
      plain.push_back(pt);
      sealed.push_back(got);
    end
    wait_drain();
    write_cfg(REG_DECRYPT_MODE, 64'h1);
    foreach (sealed[i]) begin
      send_block(sealed[i].high, sealed[i].low, got);
      if (got !== plain[i]) begin
        $display("%0t: predictor round trip: expected %h actual %h", $time, plain[i], got);
        error_count++;
      end
    end
    wait_drain();
  endtask

  // Batches of random blocks between random register settings
  task automatic test_random_traffic(input int n_blocks);
    cipher_block_t got;
    logic [HALF_W-1:0] extreme;
    int sent;
    int batch;
    sent = 0;
    while (sent < n_blocks) begin
      wait_drain();
      case ($urandom_range(0, 5))
        0: ;
        1: write_cfg(REG_KEY_HIGH, pick_half());
        2: write_cfg(REG_KEY_LOW, pick_half());
        3: begin
          write_cfg(REG_KEY_HIGH, {$urandom, $urandom});
          write_cfg(REG_KEY_LOW, {$urandom, $urandom});
        end
        4: begin
          extreme = $urandom_range(0, 1) ? '1 : '0;
          write_cfg(REG_KEY_HIGH, extreme);
          write_cfg(REG_KEY_LOW, extreme);
        end
        default: write_cfg(REG_SPARE, {$urandom, $urandom});
      endcase
      if ($urandom_range(0, 1))
        write_cfg(REG_DECRYPT_MODE, {$urandom, $urandom});

      no_idle = ($urandom_range(0, 3) == 0);
      batch = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(10, 60);
      repeat (batch) begin
        // now and then hold the next beat until the engine is empty
        if ($urandom_range(0, 39) == 0)
          wait_drain();
        send_block(pick_half(), pick_half(), got);
      end
      sent += batch;
    end
    no_idle = 1'b0;
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    block_high  = '0;
    block_low   = '0;
    out_stall   = 1'b0;
    hold_cycles = 0;
    no_idle     = 1'b0;
    error_count     = 0;
    blocks_sent     = 0;
    results_checked = 0;
    key_schedules   = 0;
    decrypt_blocks  = 0;

    shadow_key_high  = '0;
    shadow_key_low   = '0;
    shadow_decrypt   = 1'b0;
    round_keys_stale = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_roundtrip(40);
    test_random_traffic(950);
    test_roundtrip(15);

    wait_drain();
    repeat (80) @(posedge clk);

    $display("covered %0d blocks (%0d decrypt), %0d results checked, %0d key schedules,",
             blocks_sent, decrypt_blocks, results_checked, key_schedules);
    $display("with random gaps and stalls on both sides and %0d errors", error_count);
    if (error_count == 0)
      $display("sm4_block_cipher_tb: done, clean");
    else
      $display("sm4_block_cipher_tb: done, errors");
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, expected_blocks.size());
    $display("sm4_block_cipher_tb: done, errors");
    $finish;
  end

endmodule
